>>> design/aspect_fit_nearest_scaler_defines.svh
// Assertion helpers for the aspect-fit scaler.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASPECT_FIT_NEAREST_SCALER_DEFINES_SVH
`define ASPECT_FIT_NEAREST_SCALER_DEFINES_SVH

`ifndef SYNTHESIS
`define AFNS_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("afns: same-cycle check failed");
`define AFNS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("afns: next-cycle check failed");
`else
`define AFNS_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define AFNS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

>>> design/afns_pkg.sv
`timescale 1ns / 1ps
package afns_pkg;

  // Fixed field widths
  localparam int SRC_DIM_W = 12;
  localparam int DEST_W    = 17;
  localparam int SRCIDX_W  = 24;
  localparam int FRAC_W    = 16;

  // Display size defaults
  localparam int DISPLAY_WIDTH_DEF  = 384;
  localparam int DISPLAY_HEIGHT_DEF = 216;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;
  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 12'd384;
  localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 12'd216;

endpackage

>>> design/afns_in_if.sv
`timescale 1ns / 1ps
interface afns_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> design/afns_out_if.sv
`timescale 1ns / 1ps
interface afns_out_if;
  import afns_pkg::*;

  logic                valid;
  logic                ready;
  logic [DEST_W-1:0]   dest_index;
  logic [SRCIDX_W-1:0] src_index;
  logic                first_in_frame;
  logic                last_in_frame;

  modport source (output valid, output dest_index, output src_index,
                  output first_in_frame, output last_in_frame, input ready);
  modport sink   (input valid, input dest_index, input src_index,
                  input first_in_frame, input last_in_frame, output ready);
endinterface

>>> design/aspect_fit_nearest_scaler.sv
`timescale 1ns / 1ps
`include "aspect_fit_nearest_scaler_defines.svh"
// Inside a frame an accepted item passes through the MX, MY, MW, MS and FIN states; FIN waits
// until the output register is free. A new item is taken only once the sequencer is back in IDLE.
// A frame's first word first runs 4 or 5 serial divisions on one radix-2 divider, NUM_W = 28 at default sizes.
// Per-pixel cost is set by one shared multiplier used in four successive steps.
// Reset (synchronous, rst_n low): position, frame values and the output valid flag clear; source
// size registers return to 384 x 216. The first word after reset starts a frame.
module aspect_fit_nearest_scaler #(
  parameter int DISPLAY_WIDTH  = afns_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = afns_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  afns_in_if.sink                             in_ch,
  afns_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [afns_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [afns_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [afns_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import afns_pkg::*;

  localparam int COL_W = $clog2(DISPLAY_WIDTH);
  localparam int ROW_W = $clog2(DISPLAY_HEIGHT);
  localparam int DW_W  = $clog2(DISPLAY_WIDTH + 1);
  localparam int DH_W  = $clog2(DISPLAY_HEIGHT + 1);
  localparam int DEN_W = (SRC_DIM_W > DW_W) ?
                         ((SRC_DIM_W > DH_W) ? SRC_DIM_W : DH_W) :
                         ((DW_W > DH_W) ? DW_W : DH_W);
  localparam int NUM_W = DEN_W + FRAC_W;
  localparam int MA_W  = (SRC_DIM_W > COL_W) ?
                         ((SRC_DIM_W > ROW_W) ? SRC_DIM_W : ROW_W) :
                         ((COL_W > ROW_W) ? COL_W : ROW_W);
  localparam int PROD_W = MA_W + NUM_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam logic [NUM_W-1:0] DW_N   = NUM_W'(DISPLAY_WIDTH);
  localparam logic [NUM_W-1:0] DH_N   = NUM_W'(DISPLAY_HEIGHT);
  localparam logic [DW_W-1:0]  DW_V   = DW_W'(DISPLAY_WIDTH);
  localparam logic [DH_W-1:0]  DH_V   = DH_W'(DISPLAY_HEIGHT);
  localparam logic [NUM_W-1:0] DW_NUM = DW_N << FRAC_W;
  localparam logic [NUM_W-1:0] DH_NUM = DH_N << FRAC_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_MX   = 7'b0000100,
    ST_MY   = 7'b0001000,
    ST_MW   = 7'b0010000,
    ST_MS   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [5:0] {
    PH_PX   = 6'b000001,
    PH_PY   = 6'b000010,
    PH_FITH = 6'b000100,
    PH_FITW = 6'b001000,
    PH_SX   = 6'b010000,
    PH_SY   = 6'b100000
  } phase_t;

  state_t state_r;
  phase_t phase_r;

  logic [SRC_DIM_W-1:0] src_width_r, src_height_r;
  logic [SRC_DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             first_r;
  logic [NUM_W-1:0] step_x_r, step_y_r, qx_r;
  logic [DW_W-1:0]  sw_r;
  logic [DH_W-1:0]  sh_r;
  logic [DW_W-1:0]  offx;
  logic [DH_W-1:0]  offy;

  // divider
  logic [NUM_W-1:0] numq_r, numq_nxt;
  logic [DEN_W-1:0] den_r, rem_r, rem_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             div_ge;
  logic [CNT_W-1:0] cnt_r;
  logic [DW_W-1:0]  fit_w;
  logic [DH_W-1:0]  fit_h;

  // multiplier
  logic [MA_W-1:0]   mul_a;
  logic [NUM_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-FRAC_W-1:0] prod_int;

  logic [SRC_DIM_W-1:0] x2_r, y2_r;
  logic [DEST_W-1:0]    dest_r;
  logic                 last_pix;
  logic                 in_acc, out_load;
  logic [COL_W-1:0]     col_eff;
  logic [ROW_W-1:0]     row_eff;
  logic [DH_W-1:0]      dest_row;

  logic                 out_valid_r;
  logic [DEST_W-1:0]    out_dest_r;
  logic [SRCIDX_W-1:0]  out_src_r;
  logic                 out_first_r, out_last_r;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_SRC_WIDTH:  prdata = CFG_DATA_W'(src_width_r);
      REG_SRC_HEIGHT: prdata = CFG_DATA_W'(src_height_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SRC_WIDTH:  src_width_r  <= pwdata[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= pwdata[SRC_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero size as one
  assign w_eff = (src_width_r == '0)  ? SRC_DIM_W'(1) : src_width_r;
  assign h_eff = (src_height_r == '0) ? SRC_DIM_W'(1) : src_height_r;
  assign w_m1  = w_eff - SRC_DIM_W'(1);
  assign h_m1  = h_eff - SRC_DIM_W'(1);

  // Centering offsets follow the scaled window
  assign offx = (DW_V - sw_r) >> 1;
  assign offy = (DH_V - sh_r) >> 1;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign col_eff     = in_ch.restart ? '0 : col_r;
  assign row_eff     = in_ch.restart ? '0 : row_r;

  // One restoring divider step per cycle
  assign rem_sh   = {rem_r, numq_r[NUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, den_r});
  assign rem_nxt  = div_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  assign numq_nxt = {numq_r[NUM_W-2:0], div_ge};

  // Clamp a scaled size into one..display
  assign fit_w = (numq_r == '0) ? DW_W'(1) :
                 (numq_r > DW_N) ? DW_V : numq_r[DW_W-1:0];
  assign fit_h = (numq_r == '0) ? DH_W'(1) :
                 (numq_r > DH_N) ? DH_V : numq_r[DH_W-1:0];

  // Shared multiplier operand select
  assign dest_row = offy + DH_W'(row_r);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MX: begin
        mul_a = MA_W'(col_r);
        mul_b = step_x_r;
      end
      ST_MY: begin
        mul_a = MA_W'(row_r);
        mul_b = step_y_r;
      end
      ST_MW: begin
        mul_a = MA_W'(dest_row);
        mul_b = DW_N;
      end
      ST_MS: begin
        mul_a = MA_W'(y2_r);
        mul_b = NUM_W'(w_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_int = prod_r[PROD_W-1:FRAC_W];
  assign last_pix = ((DW_W'(col_r) + DW_W'(1)) >= sw_r) &&
                    ((DH_W'(row_r) + DH_W'(1)) >= sh_r);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_PX;
      cnt_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      first_r  <= 1'b0;
      step_x_r <= '0;
      step_y_r <= '0;
      sw_r     <= '0;
      sh_r     <= '0;
      qx_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            col_r   <= col_eff;
            row_r   <= row_eff;
            first_r <= (col_eff == '0) && (row_eff == '0);
            if ((col_eff == '0) && (row_eff == '0)) begin
              state_r <= ST_DIV;
              phase_r <= PH_PX;
              numq_r  <= DW_NUM;
              den_r   <= DEN_W'(w_eff);
              rem_r   <= '0;
              cnt_r   <= CNT_W'(NUM_W);
            end else begin
              state_r <= ST_MX;
            end
          end
        end
        ST_DIV: begin
          if (cnt_r != '0) begin
            numq_r <= numq_nxt;
            rem_r  <= rem_nxt;
            cnt_r  <= cnt_r - CNT_W'(1);
          end else begin
            // quotient ready: pick the next division, or start the pixel steps after the last one
            rem_r <= '0;
            cnt_r <= CNT_W'(NUM_W);
            case (phase_r)
              PH_PX: begin
                qx_r    <= numq_r;
                phase_r <= PH_PY;
                numq_r  <= DH_NUM;
                den_r   <= DEN_W'(h_eff);
              end
              PH_PY: begin
                if (qx_r == numq_r) begin
                  sw_r    <= DW_V;
                  sh_r    <= DH_V;
                  phase_r <= PH_SX;
                  numq_r  <= NUM_W'({w_eff, {FRAC_W{1'b0}}});
                  den_r   <= DEN_W'(DW_V);
                end else if (qx_r < numq_r) begin
                  sw_r    <= DW_V;
                  phase_r <= PH_FITH;
                  numq_r  <= NUM_W'(h_eff) * DW_N;
                  den_r   <= DEN_W'(w_eff);
                end else begin
                  sh_r    <= DH_V;
                  phase_r <= PH_FITW;
                  numq_r  <= NUM_W'(w_eff) * DH_N;
                  den_r   <= DEN_W'(h_eff);
                end
              end
              PH_FITH: begin
                sh_r    <= fit_h;
                phase_r <= PH_SX;
                numq_r  <= NUM_W'({w_eff, {FRAC_W{1'b0}}});
                den_r   <= DEN_W'(sw_r);
              end
              PH_FITW: begin
                sw_r    <= fit_w;
                phase_r <= PH_SX;
                numq_r  <= NUM_W'({w_eff, {FRAC_W{1'b0}}});
                den_r   <= DEN_W'(fit_w);
              end
              PH_SX: begin
                step_x_r <= numq_r + NUM_W'(1);
                phase_r  <= PH_SY;
                numq_r   <= NUM_W'({h_eff, {FRAC_W{1'b0}}});
                den_r    <= DEN_W'(sh_r);
              end
              PH_SY: begin
                step_y_r <= numq_r + NUM_W'(1);
                phase_r  <= PH_PX;
                cnt_r    <= '0;
                state_r  <= ST_MX;
              end
              default: begin
                phase_r <= PH_PX;
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MX: state_r <= ST_MY;
        ST_MY: state_r <= ST_MW;
        ST_MW: state_r <= ST_MS;
        ST_MS: state_r <= ST_FIN;
        ST_FIN: begin
          // advance the raster position as the word leaves
          if (out_load) begin
            state_r <= ST_IDLE;
            if (last_pix) begin
              col_r <= '0;
              row_r <= '0;
            end else if ((DW_W'(col_r) + DW_W'(1)) >= sw_r) begin
              col_r <= '0;
              row_r <= row_r + ROW_W'(1);
            end else begin
              col_r <= col_r + COL_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Pixel datapath: products, saturation, index sums
  always_ff @(posedge clk) begin
    if ((state_r == ST_MX) || (state_r == ST_MY) ||
        (state_r == ST_MW) || (state_r == ST_MS)) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_MY) begin
      x2_r <= (prod_int > (PROD_W-FRAC_W)'(w_m1)) ? w_m1 : prod_int[SRC_DIM_W-1:0];
    end
    if (state_r == ST_MW) begin
      y2_r <= (prod_int > (PROD_W-FRAC_W)'(h_m1)) ? h_m1 : prod_int[SRC_DIM_W-1:0];
    end
    if (state_r == ST_MS) begin
      dest_r <= DEST_W'(prod_r) + DEST_W'(offx) + DEST_W'(col_r);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dest_r  <= dest_r;
      out_src_r   <= SRCIDX_W'(prod_r) + SRCIDX_W'(x2_r);
      out_first_r <= first_r;
      out_last_r  <= last_pix;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.dest_index     = out_dest_r;
  assign out_ch.src_index      = out_src_r;
  assign out_ch.first_in_frame = out_first_r;
  assign out_ch.last_in_frame  = out_last_r;

  // Checks
  `AFNS_ASSERT_NEXT(a_acc_starts_work, clk, rst_n, in_acc, (state_r == ST_DIV) || (state_r == ST_MX))
  `AFNS_ASSERT_IMPL(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_FIN))
  `AFNS_ASSERT_IMPL(a_x2_in_range, clk, rst_n, state_r == ST_MW, x2_r <= w_m1)
  `AFNS_ASSERT_NEXT(a_last_wraps, clk, rst_n, out_load && last_pix, (col_r == '0) && (row_r == '0))

endmodule
